>>> design/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

   // pages held in the bitmap
   localparam int MAX_PAGES = 4096;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_RESERVE = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // decoded command, as queued between front and back
   typedef struct packed {
      logic        search;
      logic        mark_en;
      logic        mark_val;
      logic        zero_rej;
      logic [11:0] first;
      logic [12:0] len;
   } op_type;

endpackage
`default_nettype wire

>>> design/bpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

>>> design/bpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_front (
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [11:0]       req_first_page,
   input  wire logic [12:0]       req_run_length,
   input  wire logic              init_done,
   input  wire logic              q_not_full,
   output logic                   push,
   output bpa_pkg::op_type        push_op
);

   assign req_ready = init_done && q_not_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_op          = '0;
      push_op.first    = req_first_page;
      push_op.len      = req_run_length;
      case (req_command)
         bpa_pkg::CMD_ALLOC: begin
            if (req_run_length == '0) begin
               push_op.zero_rej = 1'b1;
            end else begin
               push_op.search   = 1'b1;
               push_op.mark_en  = 1'b1;
               push_op.mark_val = 1'b1;
            end
         end
         bpa_pkg::CMD_FREE: begin
            push_op.mark_en  = 1'b1;
            push_op.mark_val = 1'b0;
         end
         bpa_pkg::CMD_RESERVE: begin
            push_op.mark_en  = 1'b1;
            push_op.mark_val = 1'b1;
         end
         default: begin
            // undefined command: recount only
            push_op.mark_en = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/bpa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bpa_pkg::op_type   push_op,
   output logic                   not_full,
   input  wire logic              pop,
   output logic                   out_valid,
   output bpa_pkg::op_type        out_op
);

   bpa_pkg::op_type slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign not_full  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_op    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

>>> design/bpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bpa_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [12:0]       page_total,
   input  wire logic              q_valid,
   input  wire bpa_pkg::op_type   q_op,
   output logic                   q_pop,
   output logic                   init_done,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [11:0]            rsp_run_start,
   output logic [12:0]            rsp_used_pages
);

   localparam int MP = bpa_pkg::MAX_PAGES;
   localparam int NW = ((MP + 7) / 8 > 2) ? (MP + 7) / 8 : 2;
   localparam int AW = $clog2(NW);
   localparam int PW = ($clog2(MP + 1) > 14) ? $clog2(MP + 1) : 14;
   localparam logic [AW-1:0] LAST = AW'(NW - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   ia_ff, ia_in, wi_ff, wi_in;
   logic            iss_ff, iss_in, dv_ff, dv_in;
   bpa_pkg::op_type op_ff, op_in;
   logic [PW-1:0]   start_ff, start_in, run_from_ff, run_from_in, run_ff, run_in;
   logic [1:0]      status_ff, status_in;
   logic [12:0]     count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [11:0]     rsp_start_ff, rsp_start_in;
   logic [12:0]     rsp_used_ff, rsp_used_in;

   logic            we;
   logic [AW-1:0]   waddr;
   logic [7:0]      wdata, rdata;
   logic [PW-1:0]   lim, lo, hi;

   // search scratch
   logic [PW-1:0]   rf, rn, fs, p;
   logic            fnd, u;
   // sweep scratch
   logic [PW-1:0]   pm;
   logic [7:0]      nw;
   logic [3:0]      pop_cnt;

   bpa_ram #(.WIDTH(8), .DEPTH(NW)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (ia_ff),
      .rdata (rdata)
   );

   assign lim = (PW'(page_total) > PW'(MP)) ? PW'(MP) : PW'(page_total);
   assign lo  = start_ff;
   assign hi  = start_ff + PW'(op_ff.len);

   assign init_done      = (state_ff != S_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_run_start  = rsp_start_ff;
   assign rsp_used_pages = rsp_used_ff;

   always_comb begin
      rf = run_from_ff;
      rn = run_ff;
      fs = '0;
      fnd = 1'b0;
      for (int i = 0; i < 8; i++) begin
         p = PW'({wi_ff, 3'(i)});
         u = (p >= lim) || rdata[i];
         if (!fnd) begin
            if (u) begin
               rf = p + PW'(1);
               rn = '0;
            end else begin
               rn = rn + PW'(1);
               if (rn >= PW'(op_ff.len)) begin
                  fnd = 1'b1;
                  fs  = rf;
               end
            end
         end
      end
   end

   always_comb begin
      nw = rdata;
      pop_cnt = '0;
      for (int i = 0; i < 8; i++) begin
         pm = PW'({wi_ff, 3'(i)});
         if (op_ff.mark_en && pm >= lo && pm < hi && pm < lim) begin
            nw[i] = op_ff.mark_val;
         end
         if (nw[i] && pm < lim) begin
            pop_cnt = pop_cnt + 4'd1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      ia_in        = ia_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      wi_in        = wi_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      status_in    = status_ff;
      run_from_in  = run_from_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in = rsp_start_ff;
      rsp_used_in  = rsp_used_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = wi_ff;
      wdata        = nw;

      // read issue: one word a cycle; the RAM read data is registered
      if ((state_ff == S_SEARCH || state_ff == S_SWEEP) && iss_ff) begin
         dv_in = 1'b1;
         wi_in = ia_ff;
         if (ia_ff == LAST) begin
            iss_in = 1'b0;
         end else begin
            ia_in = ia_ff + AW'(1);
         end
      end

      case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            waddr = ia_ff;
            wdata = '1;
            if (ia_ff == LAST) begin
               ia_in    = '0;
               state_in = S_IDLE;
            end else begin
               ia_in = ia_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               op_in     = q_op;
               status_in = q_op.zero_rej ? bpa_pkg::ST_REJECT : bpa_pkg::ST_OK;
               start_in  = PW'(q_op.first);
               ia_in     = '0;
               iss_in    = 1'b1;
               count_in  = '0;
               run_from_in = '0;
               run_in    = '0;
               state_in  = q_op.search ? S_SEARCH : S_SWEEP;
            end
         end
         S_SEARCH: begin
            if (dv_ff) begin
               run_from_in = rf;
               run_in      = rn;
               if (fnd || wi_ff == LAST) begin
                  if (fnd) begin
                     start_in = fs;
                  end else begin
                     start_in      = '0;
                     status_in     = bpa_pkg::ST_NOFIT;
                     op_in.mark_en = 1'b0;
                  end
                  ia_in    = '0;
                  iss_in   = 1'b1;
                  dv_in    = 1'b0;
                  state_in = S_SWEEP;
               end
            end
         end
         S_SWEEP: begin
            if (dv_ff) begin
               we       = 1'b1;
               count_in = count_ff + 13'(pop_cnt);
               if (wi_ff == LAST) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = (op_ff.search && status_ff == bpa_pkg::ST_OK)
                               ? start_ff[11:0] : 12'd0;
               rsp_used_in   = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ia_ff        <= '0;
         iss_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ia_ff        <= ia_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wi_ff         <= wi_in;
      op_ff         <= op_in;
      start_ff      <= start_in;
      status_ff     <= status_in;
      run_from_ff   <= run_from_in;
      run_ff        <= run_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_used_ff   <= rsp_used_in;
   end

endmodule
`default_nettype wire

>>> design/bitmap_page_allocator_top.sv
// An allocate runs a first-fit scan, then a mark-and-recount sweep; free, reserve,
//   rejected and undefined words run the sweep only, reading the bitmap 8 pages a cycle.
// The back end works one word at a time; a two-deep queue takes new words meanwhile.
// Reset: synchronous; a clearing pass marks every page used, with req_ready low
//   throughout. page_total resets to 0.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_first_page,
   input  wire logic [12:0] req_run_length,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_run_start,
   output logic [12:0]      rsp_used_pages,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [12:0]     page_total_ff, page_total_in;
   logic            init_done, q_not_full, push, q_valid, q_pop;
   bpa_pkg::op_type push_op, q_op;

   // register file: page_total at byte address 0, anything else ignored
   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? {19'd0, page_total_ff} : 32'd0;

   always_comb begin
      page_total_in = page_total_ff;
      if (psel && penable && pwrite && paddr == 3'd0) begin
         page_total_in = pwdata[12:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_total_ff <= '0;
      end else begin
         page_total_ff <= page_total_in;
      end
   end

   // front end: takes words, decodes them into queue entries
   bpa_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_first_page (req_first_page),
      .req_run_length (req_run_length),
      .init_done      (init_done),
      .q_not_full     (q_not_full),
      .push           (push),
      .push_op        (push_op)
   );

   // two-deep decoupling queue
   bpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_op    (q_op)
   );

   // back end: bitmap RAM, search, mark and recount sweeps, response register
   bpa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .page_total     (page_total_ff),
      .q_valid        (q_valid),
      .q_op           (q_op),
      .q_pop          (q_pop),
      .init_done      (init_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_run_start  (rsp_run_start),
      .rsp_used_pages (rsp_used_pages)
   );

   // nothing taken while the bitmap is still being cleared
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_ready) else $error("word taken during clear");

   // a failed or rejected allocate reports start 0
   a_fail_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bpa_pkg::ST_OK |-> rsp_run_start == 12'd0)
      else $error("nonzero start on failure");

   // queue pop only when an entry is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> tb/bitmap_page_allocator_checker.sv
`timescale 1ns / 1ps
module bitmap_page_allocator_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_first_page,
   input  wire logic [12:0] req_run_length,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [11:0] rsp_run_start,
   input  wire logic [12:0] rsp_used_pages,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic        pready,
   output int               fail_count,
   output int               outstanding
);

   localparam int         MAX_PAGES = bpa_pkg::MAX_PAGES;
   localparam logic [2:0] ADDR_PAGE_TOTAL = 3'd0;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] run_start;
      logic [12:0] used_pages;
   } alloc_result_type;

   logic [MAX_PAGES-1:0] page_used_map;
   logic [12:0]          page_total_reg;
   alloc_result_type     result_q[$];

   function automatic int live_limit();
      return (page_total_reg < MAX_PAGES) ? int'(page_total_reg) : MAX_PAGES;
   endfunction

   function automatic void mark_pages(int first, int len, logic val);
      int lim;
      lim = live_limit();
      for (int i = 0; i < len; i++) begin
         if (first + i >= lim) break;
         page_used_map[first + i] = val;
      end
   endfunction

   function automatic alloc_result_type run_command(logic [1:0] cmd, logic [11:0] first,
                                                    logic [12:0] len);
      alloc_result_type r;
      int               lim, from, run, n;
      logic             found;
      r = '0;
      r.status = bpa_pkg::ST_OK;
      lim = live_limit();
      if (cmd == bpa_pkg::CMD_ALLOC) begin
         if (len == 0) begin
            r.status = bpa_pkg::ST_REJECT;
         end else begin
            found = 1'b0;
            from = 0;
            run = 0;
            for (int p = 0; p < lim && !found; p++) begin
               if (page_used_map[p]) begin
                  from = p + 1;
                  run = 0;
               end else begin
                  run++;
                  if (run >= int'(len)) found = 1'b1;
               end
            end
            if (found) begin
               r.run_start = from[11:0];
               mark_pages(from, int'(len), 1'b1);
            end else begin
               r.status = bpa_pkg::ST_NOFIT;
            end
         end
      end else if (cmd == bpa_pkg::CMD_FREE) begin
         mark_pages(int'(first), int'(len), 1'b0);
      end else if (cmd == bpa_pkg::CMD_RESERVE) begin
         mark_pages(int'(first), int'(len), 1'b1);
      end
      n = 0;
      for (int p = 0; p < lim; p++) n += page_used_map[p];
      r.used_pages = n[12:0];
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         page_used_map  = '1;
         page_total_reg = '0;
         result_q.delete();
         fail_count     <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_PAGE_TOTAL)
            page_total_reg = pwdata[12:0];
         if (req_valid && req_ready)
            result_q.push_back(run_command(req_command, req_first_page, req_run_length));
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result word st=%0d start=%0d used=%0d", $realtime,
                           rsp_status, rsp_run_start, rsp_used_pages);
               fail_count <= fail_count + 1;
            end else begin
               want = result_q.pop_front();
               if (want.status !== rsp_status || want.run_start !== rsp_run_start ||
                   want.used_pages !== rsp_used_pages) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp st=%0d start=%0d used=%0d got %0d %0d %0d",
                              $realtime, want.status, want.run_start, want.used_pages,
                              rsp_status, rsp_run_start, rsp_used_pages);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      outstanding = result_q.size();
   end

endmodule

>>> tb/tb_bitmap_page_allocator_top.sv
`timescale 1ns / 1ps
module tb_bitmap_page_allocator_top;

   localparam int         MAX_PAGES = bpa_pkg::MAX_PAGES;
   localparam logic [1:0] CMD_UNDEF = 2'd3;    // no such command: block must leave map alone
   localparam logic [2:0] ADDR_PAGE_TOTAL = 3'd0;
   localparam int         DRAIN_CYCLES = 2 * MAX_PAGES / 8 + 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = bpa_pkg::CMD_ALLOC;
   logic [11:0] req_first_page = '0;
   logic [12:0] req_run_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_run_start;
   logic [12:0] rsp_used_pages;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int   fail_count;
   int   outstanding;
   int   words_sent = 0;
   logic quiet_tail = 1'b0;   // last stretch: no idling on either side
   int   cur_total = 0;       // page total as last written, for shaping stimulus

   always #4 clock = ~clock;

   bitmap_page_allocator_top u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_command, .req_first_page, .req_run_length,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_run_start, .rsp_used_pages,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bitmap_page_allocator_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_command, .req_first_page, .req_run_length,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_run_start, .rsp_used_pages,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .outstanding
   );

   // Offer one word; we sit at a falling edge on entry and on exit.
   // valid stays high straight into the next word when no gap is taken.
   task automatic send_word(logic [1:0] cmd, logic [11:0] first, logic [12:0] len);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_first_page <= first;
      req_run_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Let everything drain, then idle for DRAIN_CYCLES, before touching the register.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_page_total(int value);
      wait_drained();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= ADDR_PAGE_TOTAL;
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      cur_total = (value > MAX_PAGES) ? MAX_PAGES : value;
   endtask

   // Mostly well-formed traffic: allocate small runs, free what is around, some
   // reserves; a tail of wild runs and the odd undefined command.
   task automatic random_word();
      int          pick, lim;
      logic [1:0]  cmd;
      logic [11:0] first;
      logic [12:0] len;
      lim  = (cur_total > 0) ? cur_total : 1;
      pick = $urandom_range(0, 99);
      first = 12'($urandom_range(0, lim - 1));
      len   = 13'($urandom_range(1, 16));
      if (pick < 40) begin
         cmd = bpa_pkg::CMD_ALLOC;
         if ($urandom_range(0, 19) == 0) len = 13'd0;
         else if ($urandom_range(0, 9) == 0) len = 13'($urandom_range(1, lim));
      end else if (pick < 70) begin
         cmd = bpa_pkg::CMD_FREE;
         len = 13'($urandom_range(1, 40));
      end else if (pick < 85) begin
         cmd = bpa_pkg::CMD_RESERVE;
      end else if (pick < 96) begin
         cmd   = 2'($urandom_range(0, 2));
         first = 12'($urandom_range(0, 4095));
         len   = 13'($urandom_range(0, 4096));
      end else begin
         cmd = CMD_UNDEF;
         first = 12'($urandom_range(0, 4095));
         len   = 13'($urandom_range(0, 4096));
      end
      send_word(cmd, first, len);
   endtask

   // Receiver: random stall bursts, one long hold-off to back the block up.
   initial begin
      int held;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (held == 0 && words_sent >= 200) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (8000) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Watchdog: bounds the slowest run of ~1000 words plus stalls.
   initial begin
      #60_000_000;
      $display("[bitmap_page_allocator_top] ERROR");
      $finish;
   end

   initial begin
      int totals[8];
      totals = '{64, 100, 4096, 1, 37, 8191, 200, 4096};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      // clearing pass after reset, plus margin
      repeat (MAX_PAGES / 8 + 32) @(negedge clock);

      // directed: whole map
      write_page_total(MAX_PAGES);
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd0);        // zero-length allocate, rejected
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd1);        // all used after reset: no fit
      send_word(bpa_pkg::CMD_FREE, 12'd0, 13'd4096);
      send_word(bpa_pkg::CMD_ALLOC, 12'hfff, 13'd1);      // first_page ignored, start 0
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd4096);     // too long now
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd4095);     // exactly fills the rest
      send_word(bpa_pkg::CMD_FREE, 12'd4095, 13'd1);
      send_word(bpa_pkg::CMD_FREE, 12'd4000, 13'd200);    // run past the end, clipped
      send_word(bpa_pkg::CMD_RESERVE, 12'd100, 13'd50);
      send_word(bpa_pkg::CMD_FREE, 12'd0, 13'd0);         // zero-length free: no change
      send_word(bpa_pkg::CMD_RESERVE, 12'd7, 13'd0);
      send_word(CMD_UNDEF, 12'hfff, 13'h1fff);
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd60);       // first fit in the freed tail, at page 4000
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd4096);
      send_word(bpa_pkg::CMD_FREE, 12'd0, 13'd4096);
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd4096);     // whole map in one run
      send_word(bpa_pkg::CMD_FREE, 12'd2048, 13'd4096);

      // no pages at all
      write_page_total(0);
      send_word(bpa_pkg::CMD_ALLOC, 12'd0, 13'd1);
      send_word(bpa_pkg::CMD_FREE, 12'd0, 13'd10);
      send_word(bpa_pkg::CMD_RESERVE, 12'd0, 13'd10);

      // random phases; each register change sits on a fully drained block
      foreach (totals[ph]) begin
         write_page_total(totals[ph]);
         if (ph >= 6) quiet_tail = 1'b1;
         if (ph == 3) begin
            // short total beyond which bits were left as stored
            send_word(bpa_pkg::CMD_FREE, 12'd0, 13'd4096);
         end
         repeat (120) random_word();
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("[bitmap_page_allocator_top] OK");
      end else begin
         $display("[bitmap_page_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

>>> bitmap_page_allocator_top.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_front.sv
design/bpa_queue.sv
design/bpa_back.sv
design/bitmap_page_allocator_top.sv
tb/bitmap_page_allocator_checker.sv
tb/tb_bitmap_page_allocator_top.sv
